FILE: src/mbc_pkg.sv
// mbc_pkg: shared types, codes and helper functions for the write coil transactor
// holds the modbus request byte map and the crc-16 byte update
// depends on nothing
package mbc_pkg;

   typedef enum logic [1:0] {
      ACT_COMMAND = 2'd0,
      ACT_REPLY   = 2'd1,
      ACT_TICK    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CMD_CLOSE  = 2'd0,
      CMD_OPEN   = 2'd1,
      CMD_UNK_A  = 2'd2,
      CMD_UNK_B  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_SUCCESS = 2'd0,
      ST_FAILED  = 2'd1,
      ST_TIMEOUT = 2'd2
   } status_type;

   typedef enum logic {
      KIND_TX   = 1'b0,
      KIND_DONE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_SLAVE   = 2'd0,
      CSR_COIL    = 2'd1,
      CSR_TIMEOUT = 2'd2
   } csr_index_type;

   localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [15:0] CRC_SEED        = 16'hFFFF;
   localparam logic [7:0]  COIL_ON         = 8'hFF;
   localparam logic [7:0]  SLAVE_RESET     = 8'd1;
   localparam logic [15:0] COIL_RESET      = 16'd0;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
   localparam logic [15:0] TICKS_MAX       = 16'hFFFF;
   localparam logic [2:0]  PAYLOAD_BYTES   = 3'd6;
   localparam logic [2:0]  CRC_LO_IDX      = 3'd6;
   localparam logic [2:0]  CRC_HI_IDX      = 3'd7;
   localparam int          CSR_WIDTH       = 16;

   typedef struct packed {
      logic       valid;
      status_type status;
      logic       valve;
      logic       start_burst;
      logic       open_flag;
      logic       waiting;
   } core_out_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } tx_out_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] req_byte(input logic [2:0] idx, input logic [7:0] slave,
                                           input logic [15:0] coil, input logic open_flag);
      logic [7:0] b;
      case (idx)
         3'd0: b = slave;
         3'd1: b = FUNC_WRITE_COIL;
         3'd2: b = coil[15:8];
         3'd3: b = coil[7:0];
         3'd4: b = open_flag ? COIL_ON : 8'h00;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: src/mbc_if.sv
// mbc_req_if and mbc_rsp_if: valid/ready channels for requests and results
// depends on nothing
interface mbc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [1:0] command_code;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output command_code, output rx_byte,
                   input ready);
   modport sink   (input valid, input action, input command_code, input rx_byte,
                   output ready);
endinterface

interface mbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] tx_byte;
   logic       last;
   logic [1:0] status;
   logic       valve_open;

   modport source (output valid, output kind, output tx_byte, output last, output status,
                   output valve_open, input ready);
   modport sink   (input valid, input kind, input tx_byte, input last, input status,
                   input valve_open, output ready);
endinterface

FILE: src/mbc_core.sv
// mbc_core: transaction state, reply echo and crc check, timeout counting
// depends on mbc_pkg
module mbc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [1:0]             action,
   input  logic [1:0]             command_code,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             slave_address,
   input  logic [15:0]            coil_address,
   input  logic [15:0]            timeout_ticks,
   output mbc_pkg::core_out_type  core_out
);
   import mbc_pkg::*;

   logic        waiting_ff, waiting_in;
   logic        pending_ff, pending_in;
   logic [2:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic        bad_ff, bad_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        valve_ff, valve_in;

   always_comb begin
      waiting_in = waiting_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      bad_in     = bad_ff;
      elapsed_in = elapsed_ff;
      valve_in   = valve_ff;
      core_out.valid       = 1'b0;
      core_out.status      = ST_SUCCESS;
      core_out.start_burst = 1'b0;
      core_out.open_flag   = 1'b0;
      case (action_type'(action))
         ACT_COMMAND: begin
            if (!waiting_ff) begin
               if (command_code != CMD_CLOSE && command_code != CMD_OPEN) begin
                  core_out.valid  = 1'b1;
                  core_out.status = ST_FAILED;
               end else begin
                  core_out.start_burst = 1'b1;
                  core_out.open_flag   = (command_code == CMD_OPEN);
                  waiting_in = 1'b1;
                  pending_in = (command_code == CMD_OPEN);
                  count_in   = 3'd0;
                  crc_in     = CRC_SEED;
                  bad_in     = 1'b0;
                  elapsed_in = 16'd0;
               end
            end
         end
         ACT_REPLY: begin
            if (waiting_ff) begin
               if (count_ff < PAYLOAD_BYTES) begin
                  if (rx_byte != req_byte(count_ff, slave_address, coil_address, pending_ff))
                     bad_in = 1'b1;
                  crc_in   = crc_feed(crc_ff, rx_byte);
                  count_in = count_ff + 3'd1;
               end else if (count_ff == CRC_LO_IDX) begin
                  if (rx_byte != crc_ff[7:0])
                     bad_in = 1'b1;
                  count_in = CRC_HI_IDX;
               end else begin
                  count_in   = 3'd0;
                  waiting_in = 1'b0;
                  core_out.valid = 1'b1;
                  if (bad_ff || rx_byte != crc_ff[15:8]) begin
                     core_out.status = ST_FAILED;
                  end else begin
                     core_out.status = ST_SUCCESS;
                     valve_in = pending_ff;
                  end
               end
            end
         end
         ACT_TICK: begin
            if (waiting_ff) begin
               if (elapsed_ff != TICKS_MAX)
                  elapsed_in = elapsed_ff + 16'd1;
               if (elapsed_in >= timeout_ticks) begin
                  count_in   = 3'd0;
                  waiting_in = 1'b0;
                  core_out.valid  = 1'b1;
                  core_out.status = ST_TIMEOUT;
               end
            end
         end
         default: begin
         end
      endcase
      core_out.valve   = valve_in;
      core_out.waiting = waiting_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b0;
         pending_ff <= 1'b0;
         count_ff   <= 3'd0;
         crc_ff     <= CRC_SEED;
         bad_ff     <= 1'b0;
         elapsed_ff <= 16'd0;
         valve_ff   <= 1'b0;
      end else if (fire) begin
         waiting_ff <= waiting_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         bad_ff     <= bad_in;
         elapsed_ff <= elapsed_in;
         valve_ff   <= valve_in;
      end
   end

endmodule

FILE: src/mbc_tx_burst.sv
// mbc_tx_burst: emits the eight request bytes one per cycle while advance is high, crc built on the fly
// depends on mbc_pkg
module mbc_tx_burst (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 open_flag,
   input  logic                 advance,
   input  logic [7:0]           slave_address,
   input  logic [15:0]          coil_address,
   output mbc_pkg::tx_out_type  tx_out
);
   import mbc_pkg::*;

   logic        busy_ff;
   logic [2:0]  idx_ff;
   logic        open_ff;
   logic [15:0] crc_ff;
   logic [7:0]  data;

   always_comb begin
      if (idx_ff < PAYLOAD_BYTES)
         data = req_byte(idx_ff, slave_address, coil_address, open_ff);
      else if (idx_ff == CRC_LO_IDX)
         data = crc_ff[7:0];
      else
         data = crc_ff[15:8];
   end

   assign tx_out.valid = busy_ff;
   assign tx_out.data  = data;
   assign tx_out.last  = (idx_ff == CRC_HI_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         idx_ff  <= 3'd0;
      end else if (busy_ff && advance) begin
         idx_ff <= idx_ff + 3'd1;
         if (idx_ff == CRC_HI_IDX)
            busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         open_ff <= open_flag;
         crc_ff  <= CRC_SEED;
      end else if (busy_ff && advance && idx_ff < PAYLOAD_BYTES) begin
         crc_ff <= crc_feed(crc_ff, data);
      end
   end

endmodule

FILE: src/modbus_write_coil_transactor.sv
// modbus_write_coil_transactor: modbus rtu write single coil master
// the request register feeds the result register through the combinational core;
// a command's transmit bytes pass through the burst counter and then the result register
// throughput: one request per cycle while no burst is leaving and the result register is free;
// a command stalls the request side while its transmit bytes leave one per cycle, paced by rsp.ready
// reset: synchronous, clears valids and transaction state; slave 1, coil 0, timeout 1000
module modbus_write_coil_transactor (
   input  logic                      clock,
   input  logic                      reset,
   mbc_req_if.sink                   req,
   mbc_rsp_if.source                 rsp,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [mbc_pkg::CSR_WIDTH-1:0] csr_data
);
   import mbc_pkg::*;

   logic [7:0]  slave_ff;
   logic [15:0] coil_ff;
   logic [15:0] timeout_ff;

   logic        in_valid_ff;
   logic [1:0]  in_action_ff;
   logic [1:0]  in_code_ff;
   logic [7:0]  in_rx_ff;

   logic        out_valid_ff;
   logic        out_kind_ff;
   logic [7:0]  out_tx_ff;
   logic        out_last_ff;
   logic [1:0]  out_status_ff;
   logic        out_valve_ff;

   logic         out_free;
   logic         fire;
   core_out_type core_out;
   tx_out_type   tx_out;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign fire      = in_valid_ff && !tx_out.valid && out_free;
   assign req.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff   <= SLAVE_RESET;
         coil_ff    <= COIL_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SLAVE:   slave_ff   <= csr_data[7:0];
            CSR_COIL:    coil_ff    <= csr_data[15:0];
            CSR_TIMEOUT: timeout_ff <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else if (req.ready)
         in_valid_ff <= req.valid;
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_action_ff <= req.action;
         in_code_ff   <= req.command_code;
         in_rx_ff     <= req.rx_byte;
      end
   end

   mbc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .action        (in_action_ff),
      .command_code  (in_code_ff),
      .rx_byte       (in_rx_ff),
      .slave_address (slave_ff),
      .coil_address  (coil_ff),
      .timeout_ticks (timeout_ff),
      .core_out      (core_out)
   );

   mbc_tx_burst u_tx_burst (
      .clock         (clock),
      .reset         (reset),
      .start         (fire && core_out.start_burst),
      .open_flag     (core_out.open_flag),
      .advance       (out_free),
      .slave_address (slave_ff),
      .coil_address  (coil_ff),
      .tx_out        (tx_out)
   );

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (out_free)
         out_valid_ff <= tx_out.valid || (fire && core_out.valid);
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (tx_out.valid) begin
            out_kind_ff   <= KIND_TX;
            out_tx_ff     <= tx_out.data;
            out_last_ff   <= tx_out.last;
            out_status_ff <= ST_SUCCESS;
            out_valve_ff  <= core_out.valve;
         end else begin
            out_kind_ff   <= KIND_DONE;
            out_tx_ff     <= 8'h00;
            out_last_ff   <= 1'b1;
            out_status_ff <= core_out.status;
            out_valve_ff  <= core_out.valve;
         end
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.kind       = out_kind_ff;
   assign rsp.tx_byte    = out_tx_ff;
   assign rsp.last       = out_last_ff;
   assign rsp.status     = out_status_ff;
   assign rsp.valve_open = out_valve_ff;

   a_burst_needs_wait: assert property (@(posedge clock) disable iff (reset)
      (fire && core_out.start_burst) |=> (tx_out.valid && core_out.waiting))
      else $error("request burst started without a pending transaction");

   a_done_ends_wait: assert property (@(posedge clock) disable iff (reset)
      (fire && core_out.valid) |=> !core_out.waiting)
      else $error("completion report left the transaction pending");

   a_no_request_in_burst: assert property (@(posedge clock) disable iff (reset)
      tx_out.valid |-> !fire)
      else $error("request processed while request bytes still leaving");

   a_burst_tail: assert property (@(posedge clock) disable iff (reset)
      (tx_out.valid && tx_out.last && out_free) |=> !tx_out.valid)
      else $error("request burst ran past its last byte");

endmodule
